// ===== src/hslrgb_pkg.sv =====
package hslrgb_pkg;

  localparam int unsigned CH_W = 8;
  localparam int unsigned NUM_CODES = 1 << CH_W;
  localparam longint unsigned HS_DENOM = 255;
  localparam longint unsigned L_DENOM = 510;
  localparam int unsigned PIPE_LATENCY = 7;

  typedef struct packed {
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] saturation;
    logic [CH_W-1:0] lightness_code;
  } hsl_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

// ===== src/hslrgb_prep.sv =====
module hslrgb_prep #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  hslrgb_pkg::hsl_t         hsl_i,
  output logic                     valid_o,
  output logic [FRACTION_BITS:0]   v1_o,
  output logic [FRACTION_BITS:0]   diff_o,
  output logic [FRACTION_BITS:0]   t_red_o,
  output logic [FRACTION_BITS:0]   t_green_o,
  output logic [FRACTION_BITS:0]   t_blue_o
);
  import hslrgb_pkg::*;

  localparam int unsigned W = FRACTION_BITS + 1;
  localparam int unsigned PW = 2 * FRACTION_BITS + 1;
  localparam longint unsigned ONE = longint'(1) << FRACTION_BITS;
  localparam logic [W-1:0] ONE_W = W'(ONE);
  localparam logic [W-1:0] THIRD_W = W'(ONE / 3);

  typedef logic [NUM_CODES-1:0][W-1:0] tab_t;

  function automatic tab_t build_hs_tab();
    tab_t tab;
    for (int i = 0; i < NUM_CODES; i++) begin
      tab[i] = W'((longint'(i) << FRACTION_BITS) / HS_DENOM);
    end
    return tab;
  endfunction

  function automatic tab_t build_l_tab();
    tab_t tab;
    for (int i = 0; i < NUM_CODES; i++) begin
      tab[i] = W'((ONE >> 1) + ((longint'(i) << FRACTION_BITS) / L_DENOM));
    end
    return tab;
  endfunction

  localparam tab_t HS_TAB = build_hs_tab();
  localparam tab_t L_TAB = build_l_tab();

  logic          vld1_q, vld2_q, vld3_q;
  logic [W-1:0]  h_d, s_d, l_d;
  logic          gray_d;
  logic [W-1:0]  h_q, s_q, l_q;
  logic          gray_q;
  logic [PW-1:0] sl_d, sl_q;
  logic [W-1:0]  tr_d, tb_d;
  logic [W:0]    tr_sum;
  logic [W-1:0]  tr_q, tg_q, tb_q, s2_q, l2_q;
  logic          gray2_q;
  logic [W:0]    v2_full;
  logic [W-1:0]  v2, v1_d, diff_d;
  logic [W-1:0]  v1_q, diff_q, tr3_q, tg3_q, tb3_q;

  always_comb begin
    h_d    = HS_TAB[hsl_i.hue];
    s_d    = HS_TAB[hsl_i.saturation];
    l_d    = L_TAB[hsl_i.lightness_code];
    gray_d = (hsl_i.saturation == '0);
  end

  always_comb begin
    sl_d   = PW'({{W{1'b0}}, s_q} * {{W{1'b0}}, l_q});
    tr_sum = {1'b0, h_q} + {1'b0, THIRD_W};
    tr_d   = (tr_sum > {1'b0, ONE_W}) ? W'(tr_sum - {1'b0, ONE_W}) : W'(tr_sum);
    tb_d   = (h_q < THIRD_W) ? W'(h_q + ONE_W - THIRD_W) : W'(h_q - THIRD_W);
  end

  always_comb begin
    v2_full = {1'b0, l2_q} + {1'b0, s2_q} - {1'b0, sl_q[PW-1:FRACTION_BITS]};
    v2      = W'(v2_full);
    if (gray2_q) begin
      v1_d   = l2_q;
      diff_d = '0;
    end else begin
      v1_d   = W'({l2_q, 1'b0} - {1'b0, v2});
      diff_d = W'(v2 - v1_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q     <= h_d;
    s_q     <= s_d;
    l_q     <= l_d;
    gray_q  <= gray_d;
    sl_q    <= sl_d;
    s2_q    <= s_q;
    l2_q    <= l_q;
    gray2_q <= gray_q;
    tr_q    <= tr_d;
    tg_q    <= h_q;
    tb_q    <= tb_d;
    v1_q    <= v1_d;
    diff_q  <= diff_d;
    tr3_q   <= tr_q;
    tg3_q   <= tg_q;
    tb3_q   <= tb_q;
  end

  assign valid_o   = vld3_q;
  assign v1_o      = v1_q;
  assign diff_o    = diff_q;
  assign t_red_o   = tr3_q;
  assign t_green_o = tg3_q;
  assign t_blue_o  = tb3_q;

`ifndef SYNTHESIS
  a_wrap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld3_q |-> (tr3_q <= ONE_W) && (tb3_q <= ONE_W) && (tg3_q <= ONE_W))
    else $error("Wrapped hue left the unit interval.");
  a_spread_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld3_q |-> ({1'b0, v1_q} + {1'b0, diff_q}) <= {1'b0, ONE_W})
    else $error("Upper channel value exceeds one.");
  a_gray_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld2_q && gray2_q |=> diff_q == '0)
    else $error("Gray transaction produced a nonzero spread.");
`endif

endmodule

// ===== src/hslrgb_lane.sv =====
module hslrgb_lane #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [FRACTION_BITS:0]       v1_i,
  input  logic [FRACTION_BITS:0]       diff_i,
  input  logic [FRACTION_BITS:0]       t_i,
  output logic                         valid_o,
  output logic [hslrgb_pkg::CH_W-1:0]  chan_o
);
  import hslrgb_pkg::*;

  localparam int unsigned W = FRACTION_BITS + 1;
  localparam int unsigned PW = 2 * FRACTION_BITS + 1;
  localparam longint unsigned ONE = longint'(1) << FRACTION_BITS;
  localparam logic [W-1:0] ONE_W = W'(ONE);

  logic          vld1_q, vld2_q, vld3_q, vld4_q;
  logic [W+2:0]  t6;
  logic [W:0]    t2;
  logic [W+1:0]  t3, two_one;
  logic [W-1:0]  m_d, m_q;
  logic [W-1:0]  v1a_q, da_q, v1b_q;
  logic [PW-1:0] p_d, p_q;
  logic [W-1:0]  c_d, c_q;
  logic [W+CH_W-1:0] scaled;
  logic [CH_W-1:0] byte_d, byte_q;

  always_comb begin
    t6      = {1'b0, t_i, 2'b00} + {2'b00, t_i, 1'b0};
    t2      = {t_i, 1'b0};
    t3      = {1'b0, t_i, 1'b0} + {2'b00, t_i};
    two_one = {1'b0, ONE_W, 1'b0};
    if (t6 < (W+3)'(ONE_W)) begin
      m_d = W'(t6);
    end else if (t2 < (W+1)'(ONE_W)) begin
      m_d = ONE_W;
    end else if (t3 < two_one) begin
      m_d = W'({two_one - t3, 1'b0});
    end else begin
      m_d = '0;
    end
  end

  always_comb begin
    p_d    = PW'({{W{1'b0}}, da_q} * {{W{1'b0}}, m_q});
    c_d    = W'({1'b0, v1b_q} + {1'b0, p_q[PW-1:FRACTION_BITS]});
    scaled = {c_q, {CH_W{1'b0}}} - {{CH_W{1'b0}}, c_q};
    byte_d = scaled[FRACTION_BITS+CH_W-1:FRACTION_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    v1a_q  <= v1_i;
    da_q   <= diff_i;
    p_q    <= p_d;
    v1b_q  <= v1a_q;
    c_q    <= c_d;
    byte_q <= byte_d;
  end

  assign valid_o = vld4_q;
  assign chan_o  = byte_q;

`ifndef SYNTHESIS
  a_slope_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld1_q |-> m_q <= ONE_W)
    else $error("Hue weight exceeds one.");
  a_level_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld3_q |-> c_q <= ONE_W)
    else $error("Channel level exceeds one.");
  a_full_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld1_q && m_q == ONE_W |=> p_q[PW-1:FRACTION_BITS] == $past(da_q))
    else $error("Full weight did not pass the spread through unchanged.");
`endif

endmodule

// ===== src/hsl_to_rgb_converter_core.sv =====
// Converts one hue, saturation and lightness byte triple into red, green and blue bytes.
// A transaction is taken on every clock edge with start_i high; busy_o stays low, so the
// converter accepts one pixel per cycle without gaps. Each result appears on rgb_o for a
// single cycle with done_o high, in input order. The receiver cannot hold results off and
// must take every one. The pipeline has three shared stages (table lookup, saturation
// product, channel bounds) followed by four stages in each of the three channel lanes
// (hue weight, spread product, offset add, byte scaling).
module hsl_to_rgb_converter_core #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  hslrgb_pkg::hsl_t  hsl_i,
  output logic              done_o,
  output hslrgb_pkg::rgb_t  rgb_o
);
  import hslrgb_pkg::*;

  localparam int unsigned W = FRACTION_BITS + 1;

  logic         in_fire;
  logic         prep_valid;
  logic [W-1:0] v1, diff, t_red, t_green, t_blue;
  logic         red_valid, green_valid, blue_valid;
  logic [CH_W-1:0] red, green, blue;

  assign busy_o  = 1'b0;
  assign in_fire = start_i && !busy_o;

  hslrgb_prep #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_fire),
    .hsl_i    (hsl_i),
    .valid_o  (prep_valid),
    .v1_o     (v1),
    .diff_o   (diff),
    .t_red_o  (t_red),
    .t_green_o(t_green),
    .t_blue_o (t_blue)
  );

  hslrgb_lane #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_lane_red (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(prep_valid),
    .v1_i   (v1),
    .diff_i (diff),
    .t_i    (t_red),
    .valid_o(red_valid),
    .chan_o (red)
  );

  hslrgb_lane #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_lane_green (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(prep_valid),
    .v1_i   (v1),
    .diff_i (diff),
    .t_i    (t_green),
    .valid_o(green_valid),
    .chan_o (green)
  );

  hslrgb_lane #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_lane_blue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(prep_valid),
    .v1_i   (v1),
    .diff_i (diff),
    .t_i    (t_blue),
    .valid_o(blue_valid),
    .chan_o (blue)
  );

  assign done_o      = red_valid & green_valid & blue_valid;
  assign rgb_o.red   = red;
  assign rgb_o.green = green;
  assign rgb_o.blue  = blue;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ##PIPE_LATENCY done_o)
    else $error("Accepted transaction produced no result.");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_fire, PIPE_LATENCY))
    else $error("Result without a matching transaction.");
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (red_valid == green_valid) && (green_valid == blue_valid))
    else $error("Channel lanes are out of step.");
  a_gray_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && hsl_i.saturation == '0 |-> ##PIPE_LATENCY
      (rgb_o.red == rgb_o.green) && (rgb_o.green == rgb_o.blue))
    else $error("Gray transaction produced unequal channels.");
`endif

endmodule
